/* hw/rtl/assert_macros.svh */
// assertion macros shared by the history stack rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion with explicit clock and reset
`define BFH_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion on the block clock and reset
`define BFH_ASSERT(label, prop, msg) `BFH_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

/* hw/rtl/bfh_pkg.sv */
// package with types and constants for the back/forward history stacks
package bfh_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int MAX_RESULTS     = 32;
   localparam int PAGE_W          = 64;

   typedef enum logic [1:0] {
      CMD_NEW     = 2'd0,
      CMD_BACK    = 2'd1,
      CMD_FORWARD = 2'd2,
      CMD_DISPLAY = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BACK_EMPTY = 3'd1,
      ST_FWD_EMPTY  = 3'd2,
      ST_BACK_FULL  = 3'd3,
      ST_FWD_FULL   = 3'd4,
      ST_BOTH_EMPTY = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FROM_NONE    = 2'd0,
      FROM_BACK    = 2'd1,
      FROM_FORWARD = 2'd2
   } from_type;

endpackage

/* hw/rtl/bfh_stack_mem.sv */
// single stack store: one write port, one registered read port
module bfh_stack_mem #(
   parameter int DEPTH = bfh_pkg::STACK_DEPTH_DEF,
   parameter int WIDTH = bfh_pkg::PAGE_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/back_forward_history_stacks.sv */
// Back/forward page history: new entry, back, forward and display over two stack memories.
// Move commands: the result is loaded from the registered stack memory read in the execute
//   state once the output is free; a new command is accepted only after that, back in idle.
// Display: one entry per cycle while the receiver takes them (one memory read per cycle),
//   up to min(back+forward, 32) results; input stalls for the walk.
// Synchronous reset clears both counts and the current page to zero; store contents are
//   not cleared and no clearing pass runs.
`include "assert_macros.svh"

module back_forward_history_stacks #(
   parameter int STACK_DEPTH = bfh_pkg::STACK_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   // configuration: initial_page
   input  logic          csr_wr_en,
   input  logic [63:0]   csr_wr_data,
   // request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // [63:0] entry_page
   input  logic [1:0]    req_tuser,   // [1:0] cmd
   // response channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,   // [63:0] current_page_out, [127:64] shown_page,
                                      // [130:128] status, [135:131] zero
   output logic [1:0]    rsp_tuser,   // [1:0] shown_from
   output logic          rsp_tlast    // last
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int SUM_W  = $clog2(2 * STACK_DEPTH + 1);
   localparam int LIMIT  = (2 * STACK_DEPTH < bfh_pkg::MAX_RESULTS) ?
                           2 * STACK_DEPTH : bfh_pkg::MAX_RESULTS;
   localparam int PW     = bfh_pkg::PAGE_W;

   localparam logic [CNT_W-1:0] DEPTH_V = CNT_W'(STACK_DEPTH);
   localparam logic [SUM_W-1:0] LIMIT_V = SUM_W'(LIMIT);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DISP
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     back_cnt_ff, back_cnt_in;
   logic [CNT_W-1:0]     fwd_cnt_ff, fwd_cnt_in;
   logic [PW-1:0]        current_ff, current_in;
   bfh_pkg::status_type  status_ff, status_in;
   logic                 pop_ff, pop_in;
   logic                 pop_src_ff, pop_src_in;      // 1: forward store
   logic [SUM_W-1:0]     disp_n_ff, disp_n_in;
   logic [SUM_W-1:0]     issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic                 pend_src_ff, pend_src_in;
   logic                 pend_last_ff, pend_last_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]        rsp_cur_ff, rsp_cur_in;
   logic [PW-1:0]        rsp_shown_ff, rsp_shown_in;
   bfh_pkg::from_type    rsp_from_ff, rsp_from_in;
   bfh_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 back_wr_en, back_rd_en, fwd_wr_en, fwd_rd_en;
   logic [ADDR_W-1:0]    back_wr_addr, back_rd_addr, fwd_wr_addr, fwd_rd_addr;
   logic [PW-1:0]        back_rd_data, fwd_rd_data;

   logic                 req_fire, out_free, issue_go;
   bfh_pkg::cmd_type     cmd;
   logic [CNT_W-1:0]     back_dec, fwd_dec;
   logic [SUM_W-1:0]     total, back_ext, fwd_idx, pop_data_n;
   logic [PW-1:0]        pop_data;

   // the walk reads one store at a time while moves read one and write the other,
   // and every read comes after the write of its entry is registered: no forwarding needed
   bfh_stack_mem #(.DEPTH(STACK_DEPTH), .WIDTH(PW)) u_back_mem (
      .clock   (clock),
      .wr_en   (back_wr_en),
      .wr_addr (back_wr_addr),
      .wr_data (current_ff),
      .rd_en   (back_rd_en),
      .rd_addr (back_rd_addr),
      .rd_data (back_rd_data)
   );

   bfh_stack_mem #(.DEPTH(STACK_DEPTH), .WIDTH(PW)) u_fwd_mem (
      .clock   (clock),
      .wr_en   (fwd_wr_en),
      .wr_addr (fwd_wr_addr),
      .wr_data (current_ff),
      .rd_en   (fwd_rd_en),
      .rd_addr (fwd_rd_addr),
      .rd_data (fwd_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign cmd        = bfh_pkg::cmd_type'(req_tuser);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign back_dec   = back_cnt_ff - CNT_W'(1);
   assign fwd_dec    = fwd_cnt_ff - CNT_W'(1);
   assign back_ext   = SUM_W'(back_cnt_ff);
   assign total      = back_ext + SUM_W'(fwd_cnt_ff);
   assign fwd_idx    = issue_ff - back_ext;
   assign pop_data   = pop_src_ff ? fwd_rd_data : back_rd_data;
   assign pop_data_n = disp_n_ff - SUM_W'(1);
   assign issue_go   = (state_ff == S_DISP) && (issue_ff < disp_n_ff) &&
                       (!pend_ff || out_free);

   always_comb begin
      state_in      = state_ff;
      back_cnt_in   = back_cnt_ff;
      fwd_cnt_in    = fwd_cnt_ff;
      current_in    = current_ff;
      status_in     = status_ff;
      pop_in        = pop_ff;
      pop_src_in    = pop_src_ff;
      disp_n_in     = disp_n_ff;
      issue_in      = issue_ff;
      pend_in       = pend_ff;
      pend_src_in   = pend_src_ff;
      pend_last_in  = pend_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_cur_in    = rsp_cur_ff;
      rsp_shown_in  = rsp_shown_ff;
      rsp_from_in   = rsp_from_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      back_wr_en    = 1'b0;
      back_wr_addr  = back_cnt_ff[ADDR_W-1:0];
      back_rd_en    = 1'b0;
      back_rd_addr  = back_dec[ADDR_W-1:0];
      fwd_wr_en     = 1'b0;
      fwd_wr_addr   = fwd_cnt_ff[ADDR_W-1:0];
      fwd_rd_en     = 1'b0;
      fwd_rd_addr   = fwd_dec[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               status_in = bfh_pkg::ST_OK;
               pop_in    = 1'b0;
               state_in  = S_EXEC;
               unique case (cmd)
                  bfh_pkg::CMD_NEW: begin
                     if (back_cnt_ff < DEPTH_V) begin
                        back_wr_en  = 1'b1;
                        back_cnt_in = back_cnt_ff + CNT_W'(1);
                     end else begin
                        status_in = bfh_pkg::ST_BACK_FULL;
                     end
                     current_in = req_tdata;
                  end
                  bfh_pkg::CMD_BACK: begin
                     if (back_cnt_ff == '0) begin
                        status_in = bfh_pkg::ST_BACK_EMPTY;
                     end else begin
                        back_rd_en  = 1'b1;
                        back_cnt_in = back_dec;
                        pop_in      = 1'b1;
                        pop_src_in  = 1'b0;
                        if (fwd_cnt_ff < DEPTH_V) begin
                           fwd_wr_en  = 1'b1;
                           fwd_cnt_in = fwd_cnt_ff + CNT_W'(1);
                        end else begin
                           status_in = bfh_pkg::ST_FWD_FULL;
                        end
                     end
                  end
                  bfh_pkg::CMD_FORWARD: begin
                     if (fwd_cnt_ff == '0) begin
                        status_in = bfh_pkg::ST_FWD_EMPTY;
                     end else begin
                        fwd_rd_en  = 1'b1;
                        fwd_cnt_in = fwd_dec;
                        pop_in     = 1'b1;
                        pop_src_in = 1'b1;
                        if (back_cnt_ff < DEPTH_V) begin
                           back_wr_en  = 1'b1;
                           back_cnt_in = back_cnt_ff + CNT_W'(1);
                        end else begin
                           status_in = bfh_pkg::ST_BACK_FULL;
                        end
                     end
                  end
                  bfh_pkg::CMD_DISPLAY: begin
                     if (total == '0) begin
                        status_in = bfh_pkg::ST_BOTH_EMPTY;
                     end else begin
                        if (back_cnt_ff == '0) begin
                           status_in = bfh_pkg::ST_BACK_EMPTY;
                        end else if (fwd_cnt_ff == '0) begin
                           status_in = bfh_pkg::ST_FWD_EMPTY;
                        end
                        disp_n_in = (total > LIMIT_V) ? LIMIT_V : total;
                        issue_in  = '0;
                        pend_in   = 1'b0;
                        state_in  = S_DISP;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cur_in    = pop_ff ? pop_data : current_ff;
               current_in    = pop_ff ? pop_data : current_ff;
               rsp_shown_in  = '0;
               rsp_from_in   = bfh_pkg::FROM_NONE;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DISP: begin
            // read of the next entry overlaps the hand-off of the pending one
            if (pend_ff && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cur_in    = current_ff;
               rsp_shown_in  = pend_src_ff ? fwd_rd_data : back_rd_data;
               rsp_from_in   = pend_src_ff ? bfh_pkg::FROM_FORWARD : bfh_pkg::FROM_BACK;
               rsp_status_in = status_ff;
               rsp_last_in   = pend_last_ff;
               pend_in       = 1'b0;
               if (pend_last_ff) begin
                  state_in = S_IDLE;
               end
            end
            if (issue_go) begin
               if (issue_ff < back_ext) begin
                  back_rd_en   = 1'b1;
                  back_rd_addr = issue_ff[ADDR_W-1:0];
                  pend_src_in  = 1'b0;
               end else begin
                  fwd_rd_en   = 1'b1;
                  fwd_rd_addr = fwd_idx[ADDR_W-1:0];
                  pend_src_in = 1'b1;
               end
               pend_in      = 1'b1;
               pend_last_in = (issue_ff == pop_data_n);
               issue_in     = issue_ff + SUM_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // initial_page loads the current page
      if (csr_wr_en) begin
         current_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         back_cnt_ff  <= '0;
         fwd_cnt_ff   <= '0;
         current_ff   <= '0;
         pend_ff      <= 1'b0;
         issue_ff     <= '0;
         disp_n_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         back_cnt_ff  <= back_cnt_in;
         fwd_cnt_ff   <= fwd_cnt_in;
         current_ff   <= current_in;
         pend_ff      <= pend_in;
         issue_ff     <= issue_in;
         disp_n_ff    <= disp_n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff     <= status_in;
      pop_ff        <= pop_in;
      pop_src_ff    <= pop_src_in;
      pend_src_ff   <= pend_src_in;
      pend_last_ff  <= pend_last_in;
      rsp_cur_ff    <= rsp_cur_in;
      rsp_shown_ff  <= rsp_shown_in;
      rsp_from_ff   <= rsp_from_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_status_ff, rsp_shown_ff, rsp_cur_ff};
   assign rsp_tuser  = rsp_from_ff;
   assign rsp_tlast  = rsp_last_ff;

   `BFH_ASSERT(a_back_cnt_bound, back_cnt_ff <= DEPTH_V, "back count above stack depth")
   `BFH_ASSERT(a_fwd_cnt_bound, fwd_cnt_ff <= DEPTH_V, "forward count above stack depth")
   `BFH_ASSERT(a_walk_bound, issue_ff <= LIMIT_V, "display walk ran past result limit")
   `BFH_ASSERT(a_busy_stall, (state_ff != S_IDLE) |-> !req_tready, "input taken while busy")
   `BFH_ASSERT(a_pend_in_walk, pend_ff |-> (state_ff == S_DISP), "pending entry outside walk")
   `BFH_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=>
      (rsp_tvalid && $stable(rsp_tdata)), "response changed while stalled")

endmodule

/* dv/back_forward_history_stacks_tb.sv */
// testbench for the back/forward history stacks: directed and random command streams
module back_forward_history_stacks_tb;

   localparam int DEPTH = bfh_pkg::STACK_DEPTH_DEF;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [63:0]         current;
      logic [63:0]         shown;
      bfh_pkg::from_type   src;
      bfh_pkg::status_type status;
      logic                last;
   } history_view_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_wr_en;
   logic [63:0]   csr_wr_data;
   logic          req_tvalid;
   logic          req_tready;
   logic [63:0]   req_tdata;   // [63:0] entry_page
   logic [1:0]    req_tuser;   // [1:0] cmd
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [135:0]  rsp_tdata;   // [63:0] current_page_out, [127:64] shown_page, [130:128] status
   logic [1:0]    rsp_tuser;   // [1:0] shown_from
   logic          rsp_tlast;

   // local copy of the history state
   logic [63:0]   back_mem [DEPTH];
   logic [63:0]   fwd_mem [DEPTH];
   int            back_cnt;
   int            fwd_cnt;
   logic [63:0]   cur_page;

   history_view_type pending_views [$];
   int            mismatch_count = 0;
   bit            idle_on = 1'b1;
   int            rx_hold = 0;
   int            rx_stall = 0;

   back_forward_history_stacks #(.STACK_DEPTH(DEPTH)) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] rand_page();
      return {$urandom, $urandom};
   endfunction

   // applies one command to the local history and queues the views it produces
   task automatic advance_history(input bfh_pkg::cmd_type op, input logic [63:0] page);
      bfh_pkg::status_type st;
      history_view_type    v;
      int                  total;
      st = bfh_pkg::ST_OK;
      if (op == bfh_pkg::CMD_DISPLAY) begin
         if (back_cnt == 0 && fwd_cnt == 0) begin
            v = '{cur_page, 64'd0, bfh_pkg::FROM_NONE, bfh_pkg::ST_BOTH_EMPTY, 1'b1};
            pending_views.push_back(v);
         end else begin
            if (back_cnt == 0) st = bfh_pkg::ST_BACK_EMPTY;
            else if (fwd_cnt == 0) st = bfh_pkg::ST_FWD_EMPTY;
            total = back_cnt + fwd_cnt;
            if (total > bfh_pkg::MAX_RESULTS) total = bfh_pkg::MAX_RESULTS;
            for (int k = 0; k < total; k++) begin
               if (k < back_cnt) v = '{cur_page, back_mem[k], bfh_pkg::FROM_BACK, st, 1'b0};
               else v = '{cur_page, fwd_mem[k - back_cnt], bfh_pkg::FROM_FORWARD, st, 1'b0};
               v.last = (k == total - 1);
               pending_views.push_back(v);
            end
         end
      end else begin
         case (op)
            bfh_pkg::CMD_NEW: begin
               if (back_cnt >= DEPTH) st = bfh_pkg::ST_BACK_FULL;
               else begin
                  back_mem[back_cnt] = cur_page;
                  back_cnt++;
               end
               cur_page = page;
            end
            bfh_pkg::CMD_BACK: begin
               if (back_cnt == 0) st = bfh_pkg::ST_BACK_EMPTY;
               else begin
                  if (fwd_cnt >= DEPTH) st = bfh_pkg::ST_FWD_FULL;
                  else begin
                     fwd_mem[fwd_cnt] = cur_page;
                     fwd_cnt++;
                  end
                  back_cnt--;
                  cur_page = back_mem[back_cnt];
               end
            end
            default: begin
               if (fwd_cnt == 0) st = bfh_pkg::ST_FWD_EMPTY;
               else begin
                  if (back_cnt >= DEPTH) st = bfh_pkg::ST_BACK_FULL;
                  else begin
                     back_mem[back_cnt] = cur_page;
                     back_cnt++;
                  end
                  fwd_cnt--;
                  cur_page = fwd_mem[fwd_cnt];
               end
            end
         endcase
         v = '{cur_page, 64'd0, bfh_pkg::FROM_NONE, st, 1'b1};
         pending_views.push_back(v);
      end
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input bfh_pkg::cmd_type op, input logic [63:0] page);
      int gap;
      gap = pick_gap();
      repeat (gap) @(negedge clock);
      req_tuser  = op;
      req_tdata  = page;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_history(op, page);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_views.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [63:0] value);
      wait_drained();
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      cur_page    = value;
   endtask

   task automatic test_directed_commands();
      send_item(bfh_pkg::CMD_DISPLAY, 64'd0);
      send_item(bfh_pkg::CMD_BACK, ALL_ONES);
      send_item(bfh_pkg::CMD_FORWARD, ALL_ONES);
      csr_write(ALL_ONES);
      send_item(bfh_pkg::CMD_NEW, 64'd0);
      send_item(bfh_pkg::CMD_NEW, 64'hAAAA_AAAA_AAAA_AAAA);
      send_item(bfh_pkg::CMD_NEW, 64'h5555_5555_5555_5555);
      send_item(bfh_pkg::CMD_DISPLAY, ALL_ONES);
      send_item(bfh_pkg::CMD_BACK, 64'd0);
      send_item(bfh_pkg::CMD_BACK, 64'd0);
      send_item(bfh_pkg::CMD_DISPLAY, 64'd0);
      send_item(bfh_pkg::CMD_FORWARD, 64'd0);
      send_item(bfh_pkg::CMD_BACK, 64'd0);
      send_item(bfh_pkg::CMD_BACK, 64'd0);
      send_item(bfh_pkg::CMD_DISPLAY, 64'd0);
      send_item(bfh_pkg::CMD_BACK, 64'd0);
      repeat (3) send_item(bfh_pkg::CMD_FORWARD, ALL_ONES);
      send_item(bfh_pkg::CMD_FORWARD, 64'd0);
      send_item(bfh_pkg::CMD_NEW, ALL_ONES);
      send_item(bfh_pkg::CMD_DISPLAY, 64'd0);
   endtask

   // drives both stacks to full and beyond
   task automatic test_stack_limits();
      csr_write(64'd0);
      repeat (DEPTH + 2) send_item(bfh_pkg::CMD_NEW, rand_page());
      repeat (DEPTH) send_item(bfh_pkg::CMD_BACK, rand_page());
      send_item(bfh_pkg::CMD_BACK, rand_page());
      repeat (DEPTH) send_item(bfh_pkg::CMD_NEW, rand_page());
      send_item(bfh_pkg::CMD_DISPLAY, rand_page());
      send_item(bfh_pkg::CMD_NEW, rand_page());
      send_item(bfh_pkg::CMD_BACK, rand_page());
      send_item(bfh_pkg::CMD_FORWARD, rand_page());
      send_item(bfh_pkg::CMD_FORWARD, rand_page());
      send_item(bfh_pkg::CMD_DISPLAY, rand_page());
   endtask

   // receiver holds off while the sender keeps offering commands
   task automatic test_output_backpressure();
      csr_write(64'h8000_0000_0000_0001);
      idle_on = 1'b0;
      rx_hold = 400;
      for (int i = 0; i < 40; i++)
         send_item(bfh_pkg::cmd_type'(2'($urandom_range(0, 3))), rand_page());
      idle_on = 1'b1;
      wait_drained();
   endtask

   task automatic test_random_history(input int count, input int w_new, input int w_back,
                                      input int w_fwd);
      int               r;
      bfh_pkg::cmd_type op;
      for (int i = 0; i < count; i++) begin
         // a stretch without gaps at the start of each hundred
         idle_on = (i % 100) >= 25;
         r = $urandom_range(0, 99);
         if (r < w_new) op = bfh_pkg::CMD_NEW;
         else if (r < w_new + w_back) op = bfh_pkg::CMD_BACK;
         else if (r < w_new + w_back + w_fwd) op = bfh_pkg::CMD_FORWARD;
         else op = bfh_pkg::CMD_DISPLAY;
         send_item(op, rand_page());
      end
      idle_on = 1'b1;
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      history_view_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_views.size() == 0) begin
            $error("response transaction with nothing expected");
            mismatch_count++;
         end else begin
            want = pending_views.pop_front();
            compare_field("current_page_out", want.current, rsp_tdata[63:0]);
            compare_field("shown_page", want.shown, rsp_tdata[127:64]);
            compare_field("status", 64'(want.status), 64'(rsp_tdata[130:128]));
            compare_field("shown_from", 64'(want.src), 64'(rsp_tuser));
            compare_field("last", 64'(want.last), 64'(rsp_tlast));
         end
      end
   end

   // receiver: random stalls plus an optional long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold > 0) begin
            rsp_tready = 1'b0;
            rx_hold--;
         end else if (rx_stall > 0) begin
            rsp_tready = 1'b0;
            rx_stall--;
         end else begin
            rsp_tready = 1'b1;
            if (idle_on && $urandom_range(0, 99) < 30) rx_stall = pick_gap();
         end
      end
   end

   initial begin
      #48_000_000;
      $display("back_forward_history_stacks test failed");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 64'd0;
      req_tvalid  = 1'b0;
      req_tdata   = 64'd0;
      req_tuser   = bfh_pkg::CMD_NEW;
      back_cnt    = 0;
      fwd_cnt     = 0;
      cur_page    = 64'd0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_directed_commands();
      test_stack_limits();
      test_output_backpressure();
      csr_write(rand_page());
      test_random_history(170, 35, 25, 25);
      csr_write(64'h0123_4567_89AB_CDEF);
      test_random_history(70, 60, 15, 15);
      csr_write(ALL_ONES);
      test_random_history(70, 10, 60, 20);
      csr_write(64'd0);
      test_random_history(50, 15, 20, 55);

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_views.size() == 0) begin
         $display("back_forward_history_stacks test passed");
      end else begin
         if (pending_views.size() != 0)
            $error("%0d expected responses never arrived", pending_views.size());
         $display("back_forward_history_stacks test failed");
      end
      $finish;
   end

endmodule
